// ===== rtl/dbpa_pkg.sv =====
// Package for the DMA block pool allocator: shared constants, codes and the
// controller/datapath interface structs. No dependencies.
`default_nettype none
package dbpa_pkg;
    localparam int unsigned PageBytesDefault = 4096;
    localparam int unsigned MaxPagesDefault  = 16;
    localparam int unsigned UsersMax         = 1023;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOROOM  = 2'd1;
    localparam logic [1:0] ST_BADCFG  = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_ALIGNMENT  = 2'd1;
    localparam logic [1:0] CFG_BOUNDARY   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the input item and start a walk
        logic step;      // advance the walk to the slot of the next age
        logic commit;    // perform the table update for the chosen slot
        logic fresh;     // install the spare frame as the newest page
        logic finish;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic bad_cfg;
        logic oversize;
        logic age_hit;    // a valid slot of the current age exists
        logic match;      // that slot fits (alloc) or holds the address (free)
        logic last_age;   // current age is the last possible one
        logic spare_ok;
        logic table_full;
    } t_dp_stat;
endpackage
`default_nettype wire

// ===== rtl/dbpa_ctrl.sv =====
// Controller of the DMA block pool allocator: sequences the age walk.
// Depends on dbpa_pkg.
`default_nettype none
module dbpa_ctrl
    import dbpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_fire,
    input  wire logic     i_out_free,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_cmd       o_cmd,
    output logic [1:0]    o_status
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_status = ST_OK;
                if (!i_stat.is_free && i_stat.bad_cfg) begin
                    n_status = ST_BADCFG;
                    n_state  = S_DONE;
                end else if (!i_stat.is_free && i_stat.oversize) begin
                    n_status = ST_NOROOM;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.age_hit && i_stat.match) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end else if (i_stat.age_hit && !i_stat.last_age) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = S_DONE;
                    if (i_stat.is_free) begin
                        n_status = ST_UNKNOWN;
                    end else if (i_stat.spare_ok && !i_stat.table_full) begin
                        o_cmd.fresh = 1'b1;
                    end else begin
                        n_status = ST_NOROOM;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_status = r_status;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && o_cmd.fresh)) else $error("commit and fresh together");
    a_finish_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE) else $error("finish left block busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/dbpa_datapath.sv =====
// Datapath of the DMA block pool allocator: config registers, page table,
// age walk pointer and result register. Depends on dbpa_pkg.
`default_nettype none
module dbpa_datapath
    import dbpa_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PageBytesDefault,
    parameter int unsigned MAX_PAGES  = MaxPagesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_command,
    input  wire logic [31:0] i_address,
    input  wire logic [19:0] i_spare_frame,
    input  wire logic        i_spare_ok,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [1:0]  i_status,
    output t_dp_stat         o_stat,
    output logic [31:0]      o_block_address,
    output logic             o_frame_taken,
    output logic             o_frame_released,
    output logic [19:0]      o_released_frame
);
    localparam int unsigned PB = $clog2(PAGE_BYTES);
    localparam int unsigned FW = PB + 1;           // fill holds PAGE_BYTES
    localparam int unsigned SW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned AW = $clog2(MAX_PAGES + 1);

    logic [12:0] r_block_size, r_alignment;
    logic [31:0] r_boundary;

    logic        r_cmd, r_spare_ok;
    logic [31:0] r_addr;
    logic [19:0] r_spare;

    logic [MAX_PAGES-1:0] r_valid;
    logic [19:0]   r_frame [MAX_PAGES];
    logic [FW-1:0] r_fill  [MAX_PAGES];
    logic [9:0]    r_users [MAX_PAGES];
    logic [SW-1:0] r_age   [MAX_PAGES];

    logic [AW-1:0] r_cur_age;
    logic [SW-1:0] r_sel;        // slot found for the current age
    logic          r_sel_hit;

    // Derived block size.
    logic        bad_cfg, oversize;
    logic [12:0] al_eff, sz_eff;
    assign bad_cfg = (r_block_size == '0) || ((r_alignment & (r_alignment - 13'd1)) != '0);
    assign al_eff  = (r_alignment < 13'd8) ? 13'd8 : r_alignment;
    assign sz_eff  = (r_block_size < al_eff) ? al_eff : r_block_size;
    assign oversize = ({19'd0, sz_eff} > 32'(PAGE_BYTES));

    // Slot of the next age (age 0 on load), looked up and registered before its use.
    logic [AW-1:0] look_age;
    logic [SW-1:0] look_sel;
    logic          look_hit;
    assign look_age = i_cmd.load ? '0 : (r_cur_age + AW'(1));
    always_comb begin
        look_sel = '0;
        look_hit = 1'b0;
        for (int s = MAX_PAGES - 1; s >= 0; s--) begin
            if (r_valid[s] && (AW'(r_age[s]) == look_age)) begin
                look_sel = SW'(s);
                look_hit = 1'b1;
            end
        end
    end

    // Test of the selected slot.
    logic [FW-1:0] s_fill;
    logic [19:0]   s_frame;
    logic [9:0]    s_users;
    logic [44:0]   start_a, end_a;
    logic [31:0]   page_lo;
    logic          fits, has_addr;
    assign s_fill  = r_fill[r_sel];
    assign s_frame = r_frame[r_sel];
    assign s_users = r_users[r_sel];
    assign start_a = ({25'd0, s_frame} << PB) + 45'(s_fill);
    assign end_a   = start_a + 45'(sz_eff) - 45'd1;
    assign page_lo = 32'(({25'd0, s_frame} << PB));
    always_comb begin
        fits = (32'(s_fill) + 32'(sz_eff)) <= 32'(PAGE_BYTES);
        if (r_boundary != '0 &&
            (((start_a ^ end_a) & ~(45'(r_boundary) - 45'd1)) != '0))
            fits = 1'b0;
    end
    assign has_addr = (r_addr - page_lo) < 32'(PAGE_BYTES);

    logic [SW-1:0] fresh_slot;
    always_comb begin
        fresh_slot = '0;
        for (int s = MAX_PAGES - 1; s >= 0; s--)
            if (!r_valid[s]) fresh_slot = SW'(s);
    end

    assign o_stat.is_free    = r_cmd;
    assign o_stat.bad_cfg    = bad_cfg;
    assign o_stat.oversize   = oversize;
    assign o_stat.age_hit    = r_sel_hit;
    assign o_stat.match      = r_cmd ? has_addr : fits;
    assign o_stat.last_age   = (r_cur_age == AW'(MAX_PAGES - 1));
    assign o_stat.spare_ok   = r_spare_ok;
    assign o_stat.table_full = &r_valid;

    logic [9:0] users_dec;
    logic       release_pg;
    assign users_dec  = (s_users != '0) ? s_users - 10'd1 : '0;
    assign release_pg = r_cmd && users_dec == '0 && s_fill >= FW'(PAGE_BYTES);

    // Result held in pieces until the output register loads.
    logic [31:0] r_res_addr;
    logic        r_res_taken, r_res_rel;
    logic [19:0] r_res_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= 13'd64;
            r_alignment  <= 13'd8;
            r_boundary   <= '0;
            r_valid      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BLOCK_SIZE: r_block_size <= i_cfg_data[12:0];
                    CFG_ALIGNMENT:  r_alignment  <= i_cfg_data[12:0];
                    CFG_BOUNDARY:   r_boundary   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit && release_pg) begin
                r_valid[r_sel] <= 1'b0;
            end
            if (i_cmd.fresh) begin
                r_valid[fresh_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd       <= i_command;
            r_addr      <= i_address;
            r_spare     <= i_spare_frame;
            r_spare_ok  <= i_spare_ok;
            r_res_addr  <= '0;
            r_res_taken <= 1'b0;
            r_res_rel   <= 1'b0;
            r_res_frame <= '0;
        end
        if (i_cmd.load || i_cmd.step) begin
            r_cur_age <= look_age;
            r_sel     <= look_sel;
            r_sel_hit <= look_hit;
        end
        if (i_cmd.commit) begin
            if (!r_cmd) begin
                r_res_addr     <= start_a[31:0];
                r_fill[r_sel]  <= s_fill + FW'(sz_eff);
                r_users[r_sel] <= (s_users < 10'(UsersMax)) ? s_users + 10'd1 : s_users;
            end else begin
                r_users[r_sel] <= users_dec;
                if (release_pg) begin
                    r_res_rel   <= 1'b1;
                    r_res_frame <= s_frame;
                    for (int t = 0; t < MAX_PAGES; t++)
                        if (r_valid[t] && r_age[t] > r_age[r_sel])
                            r_age[t] <= r_age[t] - SW'(1);
                end
            end
        end
        if (i_cmd.fresh) begin
            for (int t = 0; t < MAX_PAGES; t++)
                if (r_valid[t]) r_age[t] <= r_age[t] + SW'(1);
            r_frame[fresh_slot] <= r_spare;
            r_fill[fresh_slot]  <= FW'(sz_eff);
            r_users[fresh_slot] <= 10'd1;
            r_age[fresh_slot]   <= '0;
            r_res_addr          <= 32'(({25'd0, r_spare} << PB));
            r_res_taken         <= 1'b1;
        end
        if (i_cmd.finish) begin
            o_block_address  <= (i_status == ST_OK) ? r_res_addr : '0;
            o_frame_taken    <= r_res_taken;
            o_frame_released <= r_res_rel;
            o_released_frame <= r_res_frame;
        end
    end

`ifndef SYNTHESIS
    a_release_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && release_pg) |-> r_cmd) else $error("release on alloc");
    a_fresh_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fresh |-> !(&r_valid)) else $error("fresh page into full table");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> r_valid[r_sel]) else $error("commit on empty slot");
`endif
endmodule
`default_nettype wire

// ===== rtl/dma_block_pool_allocator_core.sv =====
// DMA block pool allocator, top level: controller, datapath and stream ports.
// Depends on dbpa_pkg, dbpa_ctrl and dbpa_datapath.
//
// Usage: one command transaction enters on the s_axis group and one result
// transaction leaves on the m_axis group. An alloc carves a block from the
// newest page with room, or installs the offered spare frame; a free looks
// up the page by DMA address and may release it.
// Sequence: an alloc refused by the configuration checks goes from the check
// state straight to done; any other command walks the table ages, newest to
// oldest, up to MAX_PAGES of them. There is a single table walk pointer, so
// one item is in flight at a time, and the next command is taken the cycle
// after the result loads.
// Configuration: i_cfg_we with i_cfg_index 0 block size, 1 alignment,
// 2 boundary; write only while no transaction is in flight.
// Reset (synchronous, active low) empties the page table and restores the
// default configuration: block size 64, alignment 8, no boundary.
// Stall: the result sits in the output register until taken; the next
// command can be accepted as soon as the previous result has been loaded
// into that register, and its own result waits for the register to empty.
`default_nettype none
module dma_block_pool_allocator_core
    import dbpa_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = PageBytesDefault,
    parameter int unsigned MAX_PAGES  = MaxPagesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: command[0], address[32:1], spare_frame[52:33], spare_ok[53], zeros
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[1:0], block_address[33:2], frame_taken[34],
    // frame_released[35], released_frame[55:36]
    output logic [55:0]      m_axis_tdata
);
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic        busy, in_fire, out_free;
    logic [1:0]  status;
    logic [1:0]  r_out_status;
    logic [31:0] blk;
    logic        taken, rel;
    logic [19:0] rframe;
    logic        r_out_valid;

    assign s_axis_tready = !busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    dbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_busy     (busy),
        .o_cmd      (cmd),
        .o_status   (status)
    );

    dbpa_datapath #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (s_axis_tdata[0]),
        .i_address        (s_axis_tdata[32:1]),
        .i_spare_frame    (s_axis_tdata[52:33]),
        .i_spare_ok       (s_axis_tdata[53]),
        .i_cmd            (cmd),
        .i_status         (status),
        .o_stat           (stat),
        .o_block_address  (blk),
        .o_frame_taken    (taken),
        .o_frame_released (rel),
        .o_released_frame (rframe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) r_out_status <= status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {rframe, rel, taken, blk, r_out_status};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!r_out_valid || m_axis_tready)) else $error("result overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("result moved");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready) else $error("second command while busy");
`endif
endmodule
`default_nettype wire

// ===== dv/dma_block_pool_allocator_core_test.sv =====
// Self-checking testbench for dma_block_pool_allocator_core: random and directed
// alloc/free transactions checked against an in-bench page table predictor.
// Depends on dbpa_pkg and the RTL of the allocator core.
`default_nettype none
module dma_block_pool_allocator_core_test;
    import dbpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAGE = 4096;
    localparam int unsigned SLOTS = 16;
    localparam int unsigned STALL_LIMIT = 5000;

    typedef struct packed {
        logic        ok;
        logic [19:0] frame;
        logic [31:0] addr;
        logic        cmd;
    } pool_cmd_t;

    typedef struct packed {
        logic [19:0] rframe;
        logic        released;
        logic        taken;
        logic [31:0] addr;
        logic [1:0]  status;
    } pool_resp_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_BLOCK_SIZE;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    dma_block_pool_allocator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Page table copy kept by the predictor.
    logic [12:0] cfg_size = 13'd64;
    logic [12:0] cfg_align = 13'd8;
    logic [31:0] cfg_bound = '0;
    logic        pg_valid [SLOTS];
    logic [19:0] pg_frame [SLOTS];
    logic [12:0] pg_fill [SLOTS];
    logic [9:0]  pg_users [SLOTS];
    logic [3:0]  pg_age [SLOTS];

    pool_cmd_t   pending_cmds[$];
    pool_resp_t  expected_resps[$];
    logic [31:0] live_blocks[$];
    int          errors = 0;
    int unsigned cyc = 0;
    int unsigned quiet_cycles = 0;

    function automatic int slot_with_age(int a);
        for (int s = 0; s < SLOTS; s++)
            if (pg_valid[s] && pg_age[s] == a) return s;
        return -1;
    endfunction

    function automatic pool_resp_t model_alloc(pool_cmd_t c);
        pool_resp_t  r;
        int unsigned eal, sz;
        int          s, fresh;
        logic [63:0] start, stop;
        r = '0;
        if (cfg_size == 0 || (cfg_align & (cfg_align - 13'd1)) != 0) begin
            r.status = ST_BADCFG;
            return r;
        end
        eal = (cfg_align < 8) ? 8 : cfg_align;
        sz = (cfg_size < eal) ? eal : cfg_size;
        if (sz > PAGE) begin
            r.status = ST_NOROOM;
            return r;
        end
        for (int a = 0; a < SLOTS; a++) begin
            s = slot_with_age(a);
            if (s < 0) break;
            if (pg_fill[s] + sz > PAGE) continue;
            start = 64'(pg_frame[s]) * PAGE + pg_fill[s];
            stop = start + sz - 1;
            if (cfg_bound != 0 && ((start ^ stop) & ~(64'(cfg_bound) - 64'd1)) != 0)
                continue;
            r.addr = start[31:0];
            pg_fill[s] = pg_fill[s] + 13'(sz);
            if (pg_users[s] != 10'h3FF) pg_users[s]++;
            return r;
        end
        fresh = -1;
        for (int t = 0; t < SLOTS; t++)
            if (!pg_valid[t] && fresh < 0) fresh = t;
        if (!c.ok || fresh < 0) begin
            r.status = ST_NOROOM;
            return r;
        end
        for (int t = 0; t < SLOTS; t++)
            if (pg_valid[t]) pg_age[t]++;
        pg_valid[fresh] = 1'b1;
        pg_frame[fresh] = c.frame;
        pg_fill[fresh] = 13'(sz);
        pg_users[fresh] = 10'd1;
        pg_age[fresh] = '0;
        r.addr = {c.frame, 12'h000};
        r.taken = 1'b1;
        return r;
    endfunction

    function automatic pool_resp_t model_free(pool_cmd_t c);
        pool_resp_t r;
        int         s;
        logic [3:0] gone;
        r = '0;
        for (int a = 0; a < SLOTS; a++) begin
            s = slot_with_age(a);
            if (s < 0) break;
            if (c.addr - {pg_frame[s], 12'h000} >= PAGE) continue;
            if (pg_users[s] != 0) pg_users[s]--;
            if (pg_users[s] == 0 && pg_fill[s] >= PAGE) begin
                gone = pg_age[s];
                pg_valid[s] = 1'b0;
                for (int t = 0; t < SLOTS; t++)
                    if (pg_valid[t] && pg_age[t] > gone) pg_age[t]--;
                r.released = 1'b1;
                r.rframe = pg_frame[s];
            end
            return r;
        end
        r.status = ST_UNKNOWN;
        return r;
    endfunction

    // Queues one command with its predicted response and tracks live blocks.
    task automatic post(logic cmd, logic [31:0] addr, logic [19:0] frame, logic ok);
        pool_cmd_t  c;
        pool_resp_t r;
        c = '{ok: ok, frame: frame, addr: addr, cmd: cmd};
        if (cmd == CMD_ALLOC) begin
            r = model_alloc(c);
            if (r.status == ST_OK) live_blocks.push_back(r.addr);
        end else begin
            r = model_free(c);
        end
        pending_cmds.push_back(c);
        expected_resps.push_back(r);
    endtask

    task automatic free_live();
        int unsigned k;
        k = $urandom_range(live_blocks.size() - 1);
        post(CMD_FREE, live_blocks[k], 20'($urandom), 1'($urandom_range(1)));
        live_blocks.delete(k);
    endtask

    function automatic logic [19:0] pick_frame();
        case ($urandom_range(9))
            0: return 20'hFFFFF;
            1, 2: return 20'($urandom);
            default: return 20'($urandom_range(7));
        endcase
    endfunction

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BLOCK_SIZE: cfg_size = val[12:0];
            CFG_ALIGNMENT:  cfg_align = val[12:0];
            default:        cfg_bound = val;
        endcase
    endtask

    // Driver: a new command goes out only once the previous one was taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_cmds.size() != 0 && (quiet_cycles != 0 || $urandom_range(99) >= 14)) begin
                s_axis_tdata <= {2'b00, pending_cmds.pop_front()};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares every response transaction with the oldest prediction.
    always @(posedge i_clk) begin
        pool_resp_t got, want;
        cyc <= cyc + 1;
        m_axis_tready <= i_rst_n && (quiet_cycles != 0 || $urandom_range(99) >= 14);
        if (cyc == 3000) quiet_cycles <= 2500;
        else if (quiet_cycles != 0) quiet_cycles <= quiet_cycles - 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_resps.size() == 0) begin
                $error("unexpected response transaction %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_resps.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.addr !== want.addr) begin
                    $error("block_address: expected %h, actual %h", want.addr, got.addr);
                    errors++;
                end
                if (got.taken !== want.taken) begin
                    $error("frame_taken: expected %0b, actual %0b", want.taken, got.taken);
                    errors++;
                end
                if (got.released !== want.released) begin
                    $error("frame_released: expected %0b, actual %0b",
                           want.released, got.released);
                    errors++;
                end
                if (got.rframe !== want.rframe) begin
                    $error("released_frame: expected %h, actual %h", want.rframe, got.rframe);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        int unsigned idle_run;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [31:0] settings [9][3];
        int unsigned n;
        for (int s = 0; s < SLOTS; s++) begin
            pg_valid[s] = 1'b0;
            pg_frame[s] = '0;
            pg_fill[s] = '0;
            pg_users[s] = '0;
            pg_age[s] = '0;
        end
        settings = '{
            '{32'd64, 32'd8, 32'd0},
            '{32'd1, 32'd0, 32'd0},
            '{32'd4096, 32'd4096, 32'd0},
            '{32'd100, 32'd16, 32'd256},
            '{32'd24, 32'd0, 32'd100},
            '{32'd512, 32'd64, 32'hFFFF_FFFF},
            '{32'd0, 32'd8, 32'd0},
            '{32'd64, 32'd3, 32'd0},
            '{32'h1FFF, 32'h1FFF, 32'd0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, spare refused, page install, reuse, free cases.
        post(CMD_ALLOC, 32'hFFFF_FFFF, 20'd5, 1'b0);
        post(CMD_FREE, 32'h0000_0000, 20'd0, 1'b0);
        post(CMD_ALLOC, 32'h0, 20'hFFFFF, 1'b1);
        post(CMD_ALLOC, 32'h0, 20'h00000, 1'b1);
        post(CMD_FREE, 32'hFFFF_F000, 20'd0, 1'b1);
        post(CMD_FREE, 32'hFFFF_F000, 20'd0, 1'b1);
        post(CMD_FREE, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
        post(CMD_FREE, 32'hDEAD_BEEF, 20'd0, 1'b0);
        live_blocks.delete();
        drain();

        // Walk the settings; a freshly full page and its frees cover release.
        for (int p = 0; p < 10; p++) begin
            write_reg(CFG_BLOCK_SIZE, settings[p % 9][0]);
            write_reg(CFG_ALIGNMENT, settings[p % 9][1]);
            write_reg(CFG_BOUNDARY, settings[p % 9][2]);
            if (p == 2) begin
                for (int k = 0; k < 18; k++) post(CMD_ALLOC, '0, 20'(k), 1'b1);
                while (live_blocks.size() != 0) free_live();
            end
            n = 50;
            for (int k = 0; k < n; k++) begin
                case ($urandom_range(9))
                    0: post(CMD_FREE, $urandom, 20'($urandom), 1'($urandom_range(1)));
                    1, 2, 3: if (live_blocks.size() != 0) free_live();
                        else post(CMD_ALLOC, $urandom, pick_frame(), 1'b1);
                    default: post(CMD_ALLOC, $urandom, pick_frame(), $urandom_range(7) != 0);
                endcase
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
